FILE: rtl/ppv_pkg.sv
// ----------------------------------------------------------------------------
// Point projection and visibility: shared package
// Widths, register indexes, codes and the side-band record of the pipeline.
// ----------------------------------------------------------------------------
package ppv_pkg;

  localparam int CFB_DEFAULT = 8;

  localparam int PT_W   = 24;
  localparam int CO_W   = 16;
  localparam int PROD_W = PT_W + CO_W;
  localparam int CST_W  = CO_W + 8;
  localparam int CLIP_W = 42;
  localparam int CMP_W  = CLIP_W + 16;
  localparam int MUL_W  = CLIP_W + 17;
  localparam int DIV_W  = 62;
  localparam int Q_W    = 17;
  localparam int MG_W   = 12;
  localparam int SCR_W  = 20;
  localparam int DEP_W  = 16;
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 3;
  localparam int IN_W   = 88;
  localparam int OUT_W  = 64;

  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [IDX_W-1:0] CFG_ROW_X    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ROW_Y    = 3'd1;
  localparam logic [IDX_W-1:0] CFG_ROW_Z    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_ROW_W    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_VIEWPORT = 3'd4;
  localparam logic [IDX_W-1:0] CFG_W_MIN    = 3'd5;
  localparam logic [IDX_W-1:0] CFG_CLIP_TOL = 3'd6;

  localparam logic [1:0] SEL_DIV  = 2'd0;
  localparam logic [1:0] SEL_ZERO = 2'd1;
  localparam logic [1:0] SEL_FULL = 2'd2;

  typedef enum logic [1:0] {
    VIS_INSIDE  = 2'd0,
    VIS_MARGIN  = 2'd1,
    VIS_OUTSIDE = 2'd2,
    VIS_OFF     = 2'd3
  } vis_t;

  typedef struct packed {
    logic            off;
    logic [MG_W-1:0] margin;
    logic [2:0][1:0] sel;
  } side_t;

endpackage

FILE: rtl/point_projection_visibility.sv
// ----------------------------------------------------------------------------
// Point projection and visibility
// Projects world points through a view-projection matrix into a viewport and
// classifies each point against an edge margin.
// ----------------------------------------------------------------------------
// Usage: write the matrix rows, viewport, w threshold and clip tolerance through
// the cfg port while no transfer is in flight. Each in_ transfer carries one
// point and margin; each out_ transfer returns its class, pixel position and
// depth, in order.
// Throughput is one point per cycle while out_tready does not hold the pipeline.
// The stages are the matrix, the clip tests, the divider (one quotient bit per
// stage) and the viewport mapping and classification.
// All stages advance together; when out_tready is low with a result waiting,
// the whole pipeline holds and in_tready drops, so nothing is lost.
// Reset empties the pipeline and restores the configuration defaults: all zero,
// except the w threshold and clip tolerance, which become one.
// ----------------------------------------------------------------------------
module point_projection_visibility #(
  parameter int COEFF_FRAC_BITS = ppv_pkg::CFB_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // point_x[23:0], point_y[47:24], point_z[71:48], margin_pixels[83:72]
  input  logic [ppv_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // visibility_class[1:0], screen_x[21:2], screen_y[41:22], screen_depth[57:42]
  output logic [ppv_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_we,
  input  logic [ppv_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ppv_pkg::CFG_W-1:0]  cfg_wdata
);
  import ppv_pkg::*;

  logic [3:0][CFG_W-1:0]    row_r;
  logic [CFG_W-1:0]         vp_r;
  logic [15:0]              wmin_r;
  logic [15:0]              tol_r;

  logic                     en;
  logic signed [PT_W-1:0]   pt [3];
  logic                     t_valid;
  logic signed [CLIP_W-1:0] t_clip [4];
  logic [MG_W-1:0]          t_margin;
  logic                     c_valid;
  logic [DIV_W-1:0]         c_num [3];
  logic [DIV_W-1:0]         c_den [3];
  side_t                    c_side;
  logic                     d_valid;
  logic [Q_W-1:0]           d_q [3];
  side_t                    d_side;
  vis_t                     vis;
  logic [SCR_W-1:0]         sx, sy;
  logic [DEP_W-1:0]         depth;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      vp_r   <= '0;
      wmin_r <= 16'd1;
      tol_r  <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_X:    row_r[0] <= cfg_wdata;
        CFG_ROW_Y:    row_r[1] <= cfg_wdata;
        CFG_ROW_Z:    row_r[2] <= cfg_wdata;
        CFG_ROW_W:    row_r[3] <= cfg_wdata;
        CFG_VIEWPORT: vp_r     <= cfg_wdata;
        CFG_W_MIN:    wmin_r   <= cfg_wdata[15:0];
        CFG_CLIP_TOL: tol_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign pt[0] = $signed(in_tdata[23:0]);
  assign pt[1] = $signed(in_tdata[47:24]);
  assign pt[2] = $signed(in_tdata[71:48]);

  ppv_transform u_transform (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (in_tvalid),
    .pt_i     (pt),
    .margin_i (in_tdata[83:72]),
    .row_i    (row_r),
    .valid_o  (t_valid),
    .clip_o   (t_clip),
    .margin_o (t_margin)
  );

  ppv_clip #(
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (t_valid),
    .clip_i   (t_clip),
    .margin_i (t_margin),
    .w_min_i  (wmin_r),
    .tol_i    (tol_r),
    .valid_o  (c_valid),
    .num_o    (c_num),
    .den_o    (c_den),
    .side_o   (c_side)
  );

  ppv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (c_valid),
    .num_i   (c_num),
    .den_i   (c_den),
    .side_i  (c_side),
    .valid_o (d_valid),
    .q_o     (d_q),
    .side_o  (d_side)
  );

  ppv_viewport u_viewport (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (d_valid),
    .q_i     (d_q),
    .side_i  (d_side),
    .vp_i    (vp_r),
    .valid_o (out_tvalid),
    .class_o (vis),
    .sx_o    (sx),
    .sy_o    (sy),
    .depth_o (depth)
  );

  assign out_tdata = {6'b0, depth, sy, sx, vis};

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");
`endif

`ifndef ASSERT_OFF
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && vis == VIS_OFF |-> sx == '0 && sy == '0 && depth == '0)
    else $error("off-screen result carries a position");
`endif

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> !$past(in_tready) && $stable(out_tdata))
    else $error("pipeline moved during a stall");
`endif

endmodule

FILE: rtl/ppv_transform.sv
// ----------------------------------------------------------------------------
// Point projection and visibility: matrix transform
// Two stages: coefficient products, then the sums giving clip x, y, z and w.
// ----------------------------------------------------------------------------
module ppv_transform (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                valid_i,
  input  logic signed [ppv_pkg::PT_W-1:0]     pt_i [3],
  input  logic [ppv_pkg::MG_W-1:0]            margin_i,
  input  logic [3:0][ppv_pkg::CFG_W-1:0]      row_i,
  output logic                                valid_o,
  output logic signed [ppv_pkg::CLIP_W-1:0]   clip_o [4],
  output logic [ppv_pkg::MG_W-1:0]            margin_o
);
  import ppv_pkg::*;

  logic                     v1_r;
  logic signed [PROD_W-1:0] prod_r [4][3];
  logic signed [CST_W-1:0]  cst_r [4];
  logic [MG_W-1:0]          margin1_r;
  logic                     v2_r;
  logic signed [CLIP_W-1:0] clip_r [4];
  logic [MG_W-1:0]          margin2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[r][k] <= $signed(row_i[r][CO_W*k +: CO_W]) * pt_i[k];
        end
        cst_r[r]  <= $signed({row_i[r][CFG_W-1 -: CO_W], 8'b0});
        clip_r[r] <= CLIP_W'(prod_r[r][0]) + CLIP_W'(prod_r[r][1])
                   + CLIP_W'(prod_r[r][2]) + CLIP_W'(cst_r[r]);
      end
      margin1_r <= margin_i;
      margin2_r <= margin1_r;
    end
  end

  assign valid_o  = v2_r;
  assign clip_o   = clip_r;
  assign margin_o = margin2_r;

endmodule

FILE: rtl/ppv_clip.sv
// ----------------------------------------------------------------------------
// Point projection and visibility: clip tests
// Three stages: w checks and sign fold, tolerance product, range test and
// preparation of the dividend and divisor of each normalized coordinate.
// ----------------------------------------------------------------------------
module ppv_clip #(
  parameter int COEFF_FRAC_BITS = ppv_pkg::CFB_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic signed [ppv_pkg::CLIP_W-1:0] clip_i [4],
  input  logic [ppv_pkg::MG_W-1:0]          margin_i,
  input  logic [15:0]                       w_min_i,
  input  logic [15:0]                       tol_i,
  output logic                              valid_o,
  output logic [ppv_pkg::DIV_W-1:0]         num_o [3],
  output logic [ppv_pkg::DIV_W-1:0]         den_o [3],
  output ppv_pkg::side_t                    side_o
);
  import ppv_pkg::*;

  logic                     v3_r, v4_r, v5_r;
  logic                     off3_r, off4_r;
  logic signed [CLIP_W-1:0] cn3_r [3];
  logic signed [CLIP_W-1:0] wn3_r;
  logic signed [CLIP_W-1:0] cn4_r [3];
  logic signed [CLIP_W-1:0] wn4_r;
  logic [CLIP_W-1:0]        cabs4_r [3];
  logic [MUL_W-1:0]         wt4_r;
  logic [MG_W-1:0]          margin3_r, margin4_r;
  logic [DIV_W-1:0]         num5_r [3];
  logic [DIV_W-1:0]         den5_r [3];
  side_t                    side5_r;

  logic signed [CLIP_W-1:0] w_abs;
  logic [CMP_W-1:0]         w_lhs, w_rhs;
  logic                     off3_nxt;
  logic [Q_W-1:0]           tol_full;
  logic                     off5_nxt;
  side_t                    side5_nxt;
  logic signed [CLIP_W:0]   num_s [3];
  logic signed [CLIP_W:0]   den_s;

  always_comb begin
    w_abs    = (clip_i[3] < 0) ? -clip_i[3] : clip_i[3];
    w_lhs    = {w_abs[CLIP_W-1:0], 16'b0};
    w_rhs    = CMP_W'(w_min_i) << (COEFF_FRAC_BITS + 8);
    off3_nxt = (clip_i[3] == '0) || (w_lhs < w_rhs);
    tol_full = {1'b1, tol_i};
  end

  always_comb begin
    off5_nxt = off4_r;
    den_s    = (CLIP_W+1)'(wn4_r) <<< 1;
    for (int l = 0; l < 3; l++) begin
      if (CMP_W'({cabs4_r[l], 16'b0}) > CMP_W'(wt4_r)) begin
        off5_nxt = 1'b1;
      end
      num_s[l] = (CLIP_W+1)'(cn4_r[l]) + (CLIP_W+1)'(wn4_r);
    end
    side5_nxt.off    = off5_nxt;
    side5_nxt.margin = margin4_r;
    for (int l = 0; l < 3; l++) begin
      if (num_s[l] <= 0) begin
        side5_nxt.sel[l] = SEL_ZERO;
      end else if (num_s[l] >= den_s) begin
        side5_nxt.sel[l] = SEL_FULL;
      end else begin
        side5_nxt.sel[l] = SEL_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= valid_i;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off3_r    <= off3_nxt;
      margin3_r <= margin_i;
      wn3_r     <= w_abs;
      for (int l = 0; l < 3; l++) begin
        cn3_r[l] <= (clip_i[3] < 0) ? -clip_i[l] : clip_i[l];
      end
      off4_r    <= off3_r;
      margin4_r <= margin3_r;
      wn4_r     <= wn3_r;
      wt4_r     <= MUL_W'($unsigned(wn3_r)) * MUL_W'(tol_full);
      for (int l = 0; l < 3; l++) begin
        cn4_r[l]   <= cn3_r[l];
        cabs4_r[l] <= (cn3_r[l] < 0) ? $unsigned(-cn3_r[l]) : $unsigned(cn3_r[l]);
      end
      side5_r <= side5_nxt;
      for (int l = 0; l < 3; l++) begin
        num5_r[l] <= (DIV_W'($unsigned(num_s[l])) << Q_W) + DIV_W'($unsigned(den_s));
        den5_r[l] <= DIV_W'($unsigned(den_s)) << 1;
      end
    end
  end

  assign valid_o = v5_r;
  assign num_o   = num5_r;
  assign den_o   = den5_r;
  assign side_o  = side5_r;

endmodule

FILE: rtl/ppv_div.sv
// ----------------------------------------------------------------------------
// Point projection and visibility: pipelined divider
// Restoring division, one quotient bit per stage, three lanes side by side.
// ----------------------------------------------------------------------------
module ppv_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  logic [ppv_pkg::DIV_W-1:0] num_i [3],
  input  logic [ppv_pkg::DIV_W-1:0] den_i [3],
  input  ppv_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [ppv_pkg::Q_W-1:0]   q_o [3],
  output ppv_pkg::side_t            side_o
);
  import ppv_pkg::*;

  logic             v_r    [Q_W];
  logic [DIV_W-1:0] rem_r  [Q_W][3];
  logic [DIV_W-1:0] dv_r   [Q_W][3];
  logic [Q_W-1:0]   q_r    [Q_W][3];
  side_t            side_r [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_st
    localparam int SH = Q_W - 1 - j;
    logic             src_v;
    logic [DIV_W-1:0] src_rem [3];
    logic [DIV_W-1:0] src_d   [3];
    logic [Q_W-1:0]   src_q   [3];
    side_t            src_side;
    logic [DIV_W-1:0] rem_nxt [3];
    logic [Q_W-1:0]   q_nxt   [3];

    if (j == 0) begin : g_src
      assign src_v    = valid_i;
      assign src_rem  = num_i;
      assign src_d    = den_i;
      assign src_q    = '{default: '0};
      assign src_side = side_i;
    end else begin : g_src
      assign src_v    = v_r[j-1];
      assign src_rem  = rem_r[j-1];
      assign src_d    = dv_r[j-1];
      assign src_q    = q_r[j-1];
      assign src_side = side_r[j-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_nxt[l] = src_rem[l];
        q_nxt[l]   = src_q[l];
        if (src_rem[l] >= (src_d[l] << SH)) begin
          rem_nxt[l]  = src_rem[l] - (src_d[l] << SH);
          q_nxt[l][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        dv_r[j]   <= src_d;
        q_r[j]    <= q_nxt;
        side_r[j] <= src_side;
      end
    end
  end

  assign valid_o = v_r[Q_W-1];
  assign q_o     = q_r[Q_W-1];
  assign side_o  = side_r[Q_W-1];

`ifndef ASSERT_OFF
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[Q_W-1] && !side_r[Q_W-1].off && side_r[Q_W-1].sel[0] == SEL_DIV
      |-> q_r[Q_W-1][0] <= ONE_Q16)
    else $error("divider quotient above one");
`endif

endmodule

FILE: rtl/ppv_viewport.sv
// ----------------------------------------------------------------------------
// Point projection and visibility: viewport mapping
// Three stages: pixel scaling, rounding with offset, edge distance and class.
// ----------------------------------------------------------------------------
module ppv_viewport (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  logic [ppv_pkg::Q_W-1:0]   q_i [3],
  input  ppv_pkg::side_t            side_i,
  input  logic [ppv_pkg::CFG_W-1:0] vp_i,
  output logic                      valid_o,
  output ppv_pkg::vis_t             class_o,
  output logic [ppv_pkg::SCR_W-1:0] sx_o,
  output logic [ppv_pkg::SCR_W-1:0] sy_o,
  output logic [ppv_pkg::DEP_W-1:0] depth_o
);
  import ppv_pkg::*;

  logic                 va_r, vb_r, vc_r;
  logic [32:0]          prod_a_r [2];
  logic [DEP_W-1:0]     dep_a_r, dep_b_r;
  logic                 off_a_r, off_b_r;
  logic [MG_W-1:0]      mg_a_r, mg_b_r;
  logic [20:0]          loc_b_r [2];
  logic [SCR_W-1:0]     res_b_r [2];
  vis_t                 class_r;
  logic [SCR_W-1:0]     sx_r, sy_r;
  logic [DEP_W-1:0]     dep_r;

  logic [Q_W-1:0]       s_val [3];
  logic [15:0]          size [2];
  logic [15:0]          offs [2];
  logic [33:0]          rnd [2];
  logic [20:0]          loc [2];
  logic [21:0]          res_sum [2];
  logic [20:0]          half [2];
  logic [20:0]          dev [2];
  logic [20:0]          dd [2];
  logic [20:0]          edge_dist;
  logic [16:0]          m_lo, m_hi;
  vis_t                 class_nxt;

  always_comb begin
    offs[0] = vp_i[15:0];
    offs[1] = vp_i[31:16];
    size[0] = vp_i[47:32];
    size[1] = vp_i[63:48];
    for (int l = 0; l < 3; l++) begin
      case (side_i.sel[l])
        SEL_ZERO: s_val[l] = '0;
        SEL_FULL: s_val[l] = ONE_Q16;
        default:  s_val[l] = (q_i[l] > ONE_Q16) ? ONE_Q16 : q_i[l];
      endcase
    end
    for (int k = 0; k < 2; k++) begin
      rnd[k]     = 34'(prod_a_r[k]) + 34'd2048;
      loc[k]     = rnd[k][32:12];
      res_sum[k] = 22'({offs[k], 4'b0}) + 22'(loc[k]);
      half[k]    = 21'(size[k]) << 3;
      dev[k]     = (loc_b_r[k] > half[k]) ? loc_b_r[k] - half[k] : half[k] - loc_b_r[k];
      dd[k]      = (dev[k] > half[k]) ? '0 : half[k] - dev[k];
    end
    edge_dist = (dd[1] < dd[0]) ? dd[1] : dd[0];
    m_lo = 17'(mg_b_r) << 4;
    m_hi = (17'(mg_b_r) + 17'd1) << 4;
    if (off_b_r) begin
      class_nxt = VIS_OFF;
    end else if (edge_dist < 21'(m_lo)) begin
      class_nxt = VIS_OUTSIDE;
    end else if (edge_dist > 21'(m_hi)) begin
      class_nxt = VIS_INSIDE;
    end else begin
      class_nxt = VIS_MARGIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= valid_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        prod_a_r[k] <= 33'(s_val[k]) * 33'(size[k]);
        loc_b_r[k]  <= loc[k];
        res_b_r[k]  <= (res_sum[k] > 22'(20'hFFFFF)) ? 20'hFFFFF : res_sum[k][SCR_W-1:0];
      end
      dep_a_r <= (s_val[2] > 17'(16'hFFFF)) ? 16'hFFFF : s_val[2][DEP_W-1:0];
      off_a_r <= side_i.off;
      mg_a_r  <= side_i.margin;
      dep_b_r <= dep_a_r;
      off_b_r <= off_a_r;
      mg_b_r  <= mg_a_r;
      class_r <= class_nxt;
      sx_r    <= off_b_r ? '0 : res_b_r[0];
      sy_r    <= off_b_r ? '0 : res_b_r[1];
      dep_r   <= off_b_r ? '0 : dep_b_r;
    end
  end

  assign valid_o = vc_r;
  assign class_o = class_r;
  assign sx_o    = sx_r;
  assign sy_o    = sy_r;
  assign depth_o = dep_r;

endmodule

FILE: bench/point_projection_visibility_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point projection and visibility: testbench
// Drives points through several matrix and viewport settings and compares each
// result with a listed value or a cycle-free model of projection and class.
// ----------------------------------------------------------------------------
module point_projection_visibility_tb;
  import ppv_pkg::*;

  localparam int COEFF_FRAC_BITS_TB = CFB_DEFAULT;

  typedef struct packed {
    logic [1:0]       cls;
    logic [SCR_W-1:0] sx;
    logic [SCR_W-1:0] sy;
    logic [DEP_W-1:0] depth;
  } proj_t;

  typedef struct {
    logic [PT_W-1:0] px;
    logic [PT_W-1:0] py;
    logic [PT_W-1:0] pz;
    logic [MG_W-1:0] mg;
    logic            typed;
    proj_t           res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = CFG_ROW_X;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic cur_typed = 1'b0;
  proj_t cur_res = '0;
  logic [CFG_W-1:0] shadow [7];
  proj_t pending_q[$];
  int errs = 0;
  logic sender_gaps = 1'b1;
  logic receiver_stalls = 1'b1;
  int stall_left = 0;

  point_projection_visibility i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clip_row(logic [63:0] r, longint p [3]);
    longint acc;
    acc = longint'($signed(r[63:48])) * 256;
    for (int k = 0; k < 3; k++) acc += longint'($signed(r[16*k +: 16])) * p[k];
    return acc;
  endfunction

  function automatic logic [63:0] magn(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [63:0] unit_pos(longint c, longint w);
    logic [63:0] num, den, s;
    num = c + w;
    den = 2 * w;
    if (c + w <= 0) return 0;
    if (num >= den) return 65536;
    s = ((num << 17) + den) / (2 * den);
    return (s > 65536) ? 65536 : s;
  endfunction

  function automatic proj_t project(logic [PT_W-1:0] px, logic [PT_W-1:0] py,
                                    logic [PT_W-1:0] pz, logic [MG_W-1:0] mg);
    proj_t r;
    longint p [3];
    longint c [3];
    longint w;
    logic [63:0] tol, s [3], sz, off, half, lc, dev, d, edge_dist, fin;
    r = '{cls: VIS_OFF, sx: '0, sy: '0, depth: '0};
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    for (int k = 0; k < 3; k++) c[k] = clip_row(shadow[k], p);
    w = clip_row(shadow[3], p);
    if (w == 0) return r;
    if ((magn(w) << 16) < (shadow[CFG_W_MIN] << (COEFF_FRAC_BITS_TB + 8))) return r;
    if (w < 0) begin
      w = -w;
      for (int k = 0; k < 3; k++) c[k] = -c[k];
    end
    tol = 65536 + shadow[CFG_CLIP_TOL];
    for (int k = 0; k < 3; k++)
      if ((magn(c[k]) << 16) > w * tol) return r;
    for (int k = 0; k < 3; k++) s[k] = unit_pos(c[k], w);
    edge_dist = 0;
    for (int k = 0; k < 2; k++) begin
      off = shadow[CFG_VIEWPORT][16*k +: 16];
      sz = shadow[CFG_VIEWPORT][32 + 16*k +: 16];
      half = sz * 8;
      lc = (s[k] * sz * 16 + 32768) >> 16;
      fin = off * 16 + lc;
      if (fin > 1048575) fin = 1048575;
      if (k == 0) r.sx = fin[SCR_W-1:0];
      else r.sy = fin[SCR_W-1:0];
      dev = (lc > half) ? lc - half : half - lc;
      d = (dev > half) ? 0 : half - dev;
      if (k == 0 || d < edge_dist) edge_dist = d;
    end
    if (edge_dist < 64'(mg) * 16) r.cls = VIS_OUTSIDE;
    else if (edge_dist > (64'(mg) + 1) * 16) r.cls = VIS_INSIDE;
    else r.cls = VIS_MARGIN;
    r.depth = (s[2] > 65535) ? 16'hFFFF : s[2][15:0];
    return r;
  endfunction

  // Expectations are formed when the point transfer is accepted.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (cur_typed) pending_q.push_back(cur_res);
      else pending_q.push_back(project(in_tdata[23:0], in_tdata[47:24],
                                       in_tdata[71:48], in_tdata[83:72]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      proj_t got, want;
      got = '{cls: out_tdata[1:0], sx: out_tdata[21:2], sy: out_tdata[41:22],
              depth: out_tdata[57:42]};
      if (pending_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result transfer %h", out_tdata);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: class %0d/%0d x %0d/%0d y %0d/%0d depth %0d/%0d",
                     want.cls, got.cls, want.sx, got.sx, want.sy, got.sy,
                     want.depth, got.depth);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 99) < 12) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                               : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send(logic [PT_W-1:0] px, logic [PT_W-1:0] py, logic [PT_W-1:0] pz,
                      logic [MG_W-1:0] mg, logic typed, proj_t res);
    int gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, mg, pz, py, px};
    cur_typed <= typed;
    cur_res <= res;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_settings(logic [CFG_W-1:0] v [7]);
    for (int i = 0; i < 7; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_wdata <= v[i];
      shadow[i] = (i < CFG_W_MIN) ? v[i] : {48'b0, v[i][15:0]};
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] near_row(int k);
    logic [63:0] r;
    for (int j = 0; j < 4; j++) begin
      if ($urandom_range(0, 9) == 0) r[16*j +: 16] = 16'($urandom());
      else r[16*j +: 16] = 16'((j == k ? 256 : 0) + int'($urandom_range(0, 64)) - 32);
    end
    return r;
  endfunction

  function automatic logic [PT_W-1:0] coord();
    int m;
    m = $urandom_range(0, 99);
    if (m < 70) return PT_W'(int'($urandom_range(0, 700)) - 350);
    if (m < 85) return PT_W'($urandom());
    case ($urandom_range(0, 3))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic logic [MG_W-1:0] margin_pick();
    case ($urandom_range(0, 9))
      0: return 12'($urandom());
      1: return $urandom_range(0, 1) ? 12'd0 : 12'hFFF;
      default: return 12'($urandom_range(0, 300));
    endcase
  endfunction

  localparam proj_t OFF_RES = '{cls: VIS_OFF, sx: 20'd0, sy: 20'd0, depth: 16'd0};
  localparam proj_t CENTER_RES = '{cls: VIS_INSIDE, sx: 20'd5280, sy: 20'd4160,
                                   depth: 16'd32768};
  localparam proj_t RIGHT_RES = '{cls: VIS_OUTSIDE, sx: 20'd10400, sy: 20'd4160,
                                  depth: 16'd32768};
  localparam proj_t FAR_RES = '{cls: VIS_INSIDE, sx: 20'd5280, sy: 20'd4160,
                                depth: 16'hFFFF};

  row_t reset_rows [3] = '{
    '{24'd0, 24'd0, 24'd0, 12'd1, 1'b1, OFF_RES},
    '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 12'hFFF, 1'b1, OFF_RES},
    '{24'h800000, 24'h7FFFFF, 24'h800000, 12'd0, 1'b1, OFF_RES}
  };

  row_t ident_rows [18] = '{
    '{24'd0, 24'd0, 24'd0, 12'd1, 1'b1, CENTER_RES},
    '{24'd256, 24'd0, 24'd0, 12'd1, 1'b1, RIGHT_RES},
    '{24'd0, 24'd0, 24'd256, 12'd1, 1'b1, FAR_RES},
    '{-24'sd256, 24'd0, 24'd0, 12'd1, 1'b0, OFF_RES},
    '{24'd0, 24'd256, 24'd0, 12'd5, 1'b0, OFF_RES},
    '{24'd0, -24'sd256, -24'sd256, 12'd5, 1'b0, OFF_RES},
    '{24'd260, 24'd0, 24'd0, 12'd2, 1'b0, OFF_RES},
    '{24'd290, 24'd0, 24'd0, 12'd2, 1'b0, OFF_RES},
    '{24'd0, 24'd0, 24'd270, 12'd2, 1'b0, OFF_RES},
    '{24'd100, 24'd50, 24'd0, 12'd0, 1'b0, OFF_RES},
    '{24'd100, 24'd50, 24'd0, 12'hFFF, 1'b0, OFF_RES},
    '{24'd250, 24'd0, 24'd0, 12'd3, 1'b0, OFF_RES},
    '{24'd248, 24'd0, 24'd0, 12'd3, 1'b0, OFF_RES},
    '{24'd252, 24'd0, 24'd0, 12'd3, 1'b0, OFF_RES},
    '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 12'd1, 1'b0, OFF_RES},
    '{24'h800000, 24'h800000, 24'h800000, 12'd1, 1'b0, OFF_RES},
    '{-24'sd128, 24'd128, -24'sd128, 12'd10, 1'b0, OFF_RES},
    '{24'd1, -24'sd1, 24'd1, 12'd1, 1'b0, OFF_RES}
  };

  initial begin
    logic [CFG_W-1:0] v [7];
    for (int i = 0; i < 7; i++) shadow[i] = '0;
    shadow[CFG_W_MIN] = 1;
    shadow[CFG_CLIP_TOL] = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (reset_rows[i])
      send(reset_rows[i].px, reset_rows[i].py, reset_rows[i].pz, reset_rows[i].mg,
           reset_rows[i].typed, reset_rows[i].res);
    settle();
    v = '{64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000, 64'h0000_0100_0000_0000,
          64'h0100_0000_0000_0000, {16'd480, 16'd640, 16'd20, 16'd10}, 64'd1,
          64'h1000};
    load_settings(v);
    foreach (ident_rows[i])
      send(ident_rows[i].px, ident_rows[i].py, ident_rows[i].pz, ident_rows[i].mg,
           ident_rows[i].typed, ident_rows[i].res);
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      sender_gaps = (ph % 3) != 1;
      receiver_stalls = (ph % 3) != 2;
      if (ph == 1) begin
        v = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
      end else if (ph == 4) begin
        for (int i = 0; i < 7; i++) v[i] = '1;
      end else begin
        for (int k = 0; k < 4; k++) v[k] = near_row(k);
        if ($urandom_range(0, 2) == 0) v[3] = -v[3];
        for (int k = 0; k < 4; k++) v[3][16*k +: 16] = ($urandom_range(0, 2) == 0)
            ? 16'(-$signed(v[3][16*k +: 16])) : v[3][16*k +: 16];
        v[4] = {16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)),
                16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000))};
        if (ph == 6) v[4] = {16'hFFFF, 16'hFFFF, 16'hFFF0, 16'hFFF0};
        if (ph == 7) v[4][47:32] = 16'd0;
        v[5] = (ph == 5) ? 64'd0 : 64'($urandom_range(0, 300));
        v[6] = 64'($urandom_range(0, 65535));
      end
      load_settings(v);
      for (int n = 0; n < 50; n++) send(coord(), coord(), coord(), margin_pick(), 1'b0,
                                        OFF_RES);
    end
    settle();
    if (errs == 0 && pending_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ppv_pkg.sv
rtl/ppv_transform.sv
rtl/ppv_clip.sv
rtl/ppv_div.sv
rtl/ppv_viewport.sv
rtl/point_projection_visibility.sv
bench/point_projection_visibility_tb.sv
